>>> src/gip_pkg.sv
package gip_pkg;

   // Default sizes of the design.
   localparam int AXES_DEFAULT            = 6;
   localparam int VIRTUAL_BUTTONS_DEFAULT = 15;
   localparam int PHYS_BUTTONS_DEFAULT    = 32;
   localparam int HATS_DEFAULT            = 4;

   // The item carries six raw axis fields; axes beyond them read zero.
   localparam int NUM_RAW_AXES = 6;

   localparam int DEAD_ZONE = 32768 / 3;
   localparam logic signed [16:0] FULL_SCALE = 17'sd32767;

   // Bit positions of the source register fields.
   localparam int SRC_PAIR_BIT = 16;
   localparam int SRC_HAT_BIT  = 17;
   localparam int SRC_OFF_BIT  = 18;

   localparam logic [7:0] DIR_HORIZONTAL = 8'd1;
   localparam logic [7:0] DIR_VERTICAL   = 8'd2;

   localparam int HAT_UP    = 0;
   localparam int HAT_RIGHT = 1;
   localparam int HAT_DOWN  = 2;
   localparam int HAT_LEFT  = 3;

   localparam logic CMD_POLL      = 1'b0;
   localparam logic CMD_CALIBRATE = 1'b1;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_MOTION  = 2'd0;
   localparam kind_type KIND_PRESS   = 2'd1;
   localparam kind_type KIND_RELEASE = 2'd2;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_AXIS_COUNT     = 3'd0;
   localparam csr_index_type CSR_BUTTON_COUNT   = 3'd1;
   localparam csr_index_type CSR_HAT_COUNT      = 3'd2;
   localparam csr_index_type CSR_TURN_SOURCE    = 3'd3;
   localparam csr_index_type CSR_FORWARD_SOURCE = 3'd4;
   localparam csr_index_type CSR_STRAFE_SOURCE  = 3'd5;
   localparam csr_index_type CSR_LOOK_SOURCE    = 3'd6;
   localparam csr_index_type CSR_INVERT_MASK    = 3'd7;

   typedef logic signed [15:0] axis_type;
   typedef logic signed [16:0] control_type;
   typedef logic signed [18:0] source_type;
   typedef logic [4:0]         index_type;

   typedef struct packed {
      logic pending;
      logic valid;
   } emit_status_type;

endpackage

>>> src/gip_req_if.sv
interface gip_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] raw_buttons;
   logic [15:0] raw_hats;
   logic signed [15:0] raw_axis_a;
   logic signed [15:0] raw_axis_b;
   logic signed [15:0] raw_axis_c;
   logic signed [15:0] raw_axis_d;
   logic signed [15:0] raw_axis_e;
   logic signed [15:0] raw_axis_f;

   modport source (
      output valid, cmd, raw_buttons, raw_hats,
      output raw_axis_a, raw_axis_b, raw_axis_c, raw_axis_d, raw_axis_e, raw_axis_f,
      input  ready
   );

   modport sink (
      input  valid, cmd, raw_buttons, raw_hats,
      input  raw_axis_a, raw_axis_b, raw_axis_c, raw_axis_d, raw_axis_e, raw_axis_f,
      output ready
   );
endinterface

>>> src/gip_rsp_if.sv
interface gip_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [4:0]  button_index;
   logic signed [16:0] look_value;
   logic signed [16:0] turn_value;
   logic signed [16:0] forward_value;
   logic signed [16:0] strafe_value;
   logic        last;

   modport source (
      output valid, kind, button_index, look_value, turn_value, forward_value,
      output strafe_value, last,
      input  ready
   );

   modport sink (
      input  valid, kind, button_index, look_value, turn_value, forward_value,
      input  strafe_value, last,
      output ready
   );
endinterface

>>> src/gamepad_input_qualifier.sv
// Gamepad input qualifier.
// An item on req_ch is either a calibrate command, which stores the present raw
// axes as offsets of the used axes and gives no result, or a poll. A poll gives
// an optional motion item with the four mapped controls, then one press item per
// newly set bit of the virtual button mask and one release item per newly
// cleared bit, in ascending bit order; the final item of a poll has last set.
// Results leave through rsp_ch from an output register.
// A calibrate item leaves the block idle. A poll has its axes corrected in
// ST_CORRECT and its controls merged and loaded into the emitter in ST_MERGE;
// then ST_EMIT moves its results into the output register, one result per
// cycle while rsp_ch does not stall, and the next item is accepted once all
// results of a poll have entered the output register. When rsp_ch stalls,
// the held result stays and the queued ones wait. The csr_ port writes one
// configuration register per cycle with csr_we. Reset clears the count and
// invert registers, sets the sources to all ones (off), clears axis offsets
// and the previous button mask, and drops any result that has not been taken.
module gamepad_input_qualifier #(
   parameter int AXES            = gip_pkg::AXES_DEFAULT,
   parameter int VIRTUAL_BUTTONS = gip_pkg::VIRTUAL_BUTTONS_DEFAULT,
   parameter int PHYS_BUTTONS    = gip_pkg::PHYS_BUTTONS_DEFAULT,
   parameter int HATS            = gip_pkg::HATS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   gip_req_if.sink                req_ch,
   gip_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  gip_pkg::csr_index_type csr_index,
   input  logic [18:0]            csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CORRECT = 4'b0010,
      ST_MERGE   = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]          axis_count_ff;
   logic [5:0]          button_count_ff;
   logic [2:0]          hat_count_ff;
   gip_pkg::source_type source_ff [4];
   logic [3:0]          invert_ff;

   logic [31:0]         buttons_ff;
   logic [15:0]         hats_ff;
   gip_pkg::axis_type   axis_raw_ff [gip_pkg::NUM_RAW_AXES];
   gip_pkg::axis_type   port_raw [gip_pkg::NUM_RAW_AXES];

   logic                accept;
   logic                idle;
   gip_pkg::emit_status_type emit_st;

   assign idle         = (state_ff == ST_IDLE);
   assign req_ch.ready = idle;
   assign accept       = req_ch.valid && req_ch.ready;

   assign port_raw[0] = req_ch.raw_axis_a;
   assign port_raw[1] = req_ch.raw_axis_b;
   assign port_raw[2] = req_ch.raw_axis_c;
   assign port_raw[3] = req_ch.raw_axis_d;
   assign port_raw[4] = req_ch.raw_axis_e;
   assign port_raw[5] = req_ch.raw_axis_f;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_count_ff   <= '0;
         button_count_ff <= '0;
         hat_count_ff    <= '0;
         for (int k = 0; k < 4; k++) begin
            source_ff[k] <= '1;
         end
         invert_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            gip_pkg::CSR_AXIS_COUNT:     axis_count_ff   <= csr_wdata[2:0];
            gip_pkg::CSR_BUTTON_COUNT:   button_count_ff <= csr_wdata[5:0];
            gip_pkg::CSR_HAT_COUNT:      hat_count_ff    <= csr_wdata[2:0];
            gip_pkg::CSR_TURN_SOURCE:    source_ff[0]    <= csr_wdata;
            gip_pkg::CSR_FORWARD_SOURCE: source_ff[1]    <= csr_wdata;
            gip_pkg::CSR_STRAFE_SOURCE:  source_ff[2]    <= csr_wdata;
            gip_pkg::CSR_LOOK_SOURCE:    source_ff[3]    <= csr_wdata;
            gip_pkg::CSR_INVERT_MASK:    invert_ff       <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buttons_ff <= req_ch.raw_buttons;
         hats_ff    <= req_ch.raw_hats;
         for (int i = 0; i < gip_pkg::NUM_RAW_AXES; i++) begin
            axis_raw_ff[i] <= port_raw[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_ch.cmd == gip_pkg::CMD_POLL) begin
               state_in = ST_CORRECT;
            end
         end
         ST_CORRECT: state_in = ST_MERGE;
         ST_MERGE:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (!emit_st.pending) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Which buttons, hats and axes the device actually has.
   logic [31:0] btn_en;
   logic [31:0] btn_eff;
   logic [15:0] hats_eff;
   logic [3:0]  hat_en;

   for (genvar b = 0; b < 32; b++) begin : g_btn_en
      assign btn_en[b] = (b < PHYS_BUTTONS) && (button_count_ff > 6'(b));
   end
   assign btn_eff = buttons_ff & btn_en;

   for (genvar h = 0; h < 4; h++) begin : g_hat_en
      assign hat_en[h] = (h < HATS) && ({1'b0, hat_count_ff} > 4'(h));
      assign hats_eff[h * 4 +: 4] = hats_ff[h * 4 +: 4] & {4{hat_en[h]}};
   end

   logic [AXES-1:0]   axis_en;
   logic [AXES-1:0]   lane_above;
   logic [AXES-1:0]   lane_below;
   gip_pkg::axis_type lane_raw [AXES];
   gip_pkg::axis_type lane_val [AXES];

   for (genvar i = 0; i < AXES; i++) begin : g_axis
      assign axis_en[i] = ({1'b0, axis_count_ff} > 4'(i));
      if (i < gip_pkg::NUM_RAW_AXES) begin : g_raw
         assign lane_raw[i] = idle ? port_raw[i] : axis_raw_ff[i];
      end else begin : g_noraw
         assign lane_raw[i] = '0;
      end
      gip_axis_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .capture (accept && req_ch.cmd == gip_pkg::CMD_CALIBRATE && axis_en[i]),
         .step    (state_ff == ST_CORRECT),
         .raw     (lane_raw[i]),
         .value   (lane_val[i]),
         .above   (lane_above[i]),
         .below   (lane_below[i])
      );
   end

   gip_pkg::control_type       ctrl_val [4];
   logic [VIRTUAL_BUTTONS-1:0] ctrl_claim [4];
   logic [VIRTUAL_BUTTONS-1:0] claimed_any;

   for (genvar k = 0; k < 4; k++) begin : g_ctrl
      gip_ctrl_lane #(
         .AXES            (AXES),
         .VIRTUAL_BUTTONS (VIRTUAL_BUTTONS)
      ) u_ctrl (
         .src      (source_ff[k]),
         .invert   (invert_ff[k]),
         .buttons  (btn_eff),
         .hats     (hats_eff),
         .axis_val (lane_val),
         .axis_en  (axis_en),
         .value    (ctrl_val[k]),
         .claimed  (ctrl_claim[k])
      );
   end

   assign claimed_any = ctrl_claim[0] | ctrl_claim[1] | ctrl_claim[2] | ctrl_claim[3];

   gip_emit #(
      .AXES            (AXES),
      .VIRTUAL_BUTTONS (VIRTUAL_BUTTONS)
   ) u_emit (
      .clock   (clock),
      .reset   (reset),
      .load    (state_ff == ST_MERGE),
      .buttons (btn_eff[VIRTUAL_BUTTONS-1:0] & ~claimed_any),
      .above   (lane_above & axis_en),
      .below   (lane_below & axis_en),
      .hat0    (hats_eff[3:0]),
      .turn    (ctrl_val[0]),
      .forward (ctrl_val[1]),
      .strafe  (ctrl_val[2]),
      .look    (ctrl_val[3]),
      .rsp_ch  (rsp_ch),
      .status  (emit_st)
   );

`ifndef SYNTH
   a_poll_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.cmd == gip_pkg::CMD_POLL) |=> state_ff == ST_CORRECT)
      else $error("accepted poll did not start axis correction");

   a_calib_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.cmd == gip_pkg::CMD_CALIBRATE) |=> (idle && !emit_st.pending))
      else $error("calibrate item produced work");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      idle |-> !emit_st.pending)
      else $error("results still queued while accepting items");

   a_merge_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |=> (state_ff == ST_EMIT))
      else $error("merge stage did not hand over to the emitter");
`endif

endmodule

>>> src/gip_axis_lane.sv
module gip_axis_lane (
   input  logic              clock,
   input  logic              reset,
   input  logic              capture,
   input  logic              step,
   input  gip_pkg::axis_type raw,
   output gip_pkg::axis_type value,
   output logic              above,
   output logic              below
);

   gip_pkg::axis_type offset_ff, offset_in;
   gip_pkg::axis_type value_ff, value_in;
   logic signed [16:0] diff;

   always_comb begin
      diff = {raw[15], raw} - {offset_ff[15], offset_ff};
      // Overflow of the 16-bit range shows as a mismatch of the two top bits.
      if (diff[16] != diff[15]) begin
         value_in = diff[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         value_in = diff[15:0];
      end
      offset_in = capture ? raw : offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;
   assign above = value_ff > gip_pkg::DEAD_ZONE;
   assign below = value_ff < -gip_pkg::DEAD_ZONE;

endmodule

>>> src/gip_ctrl_lane.sv
module gip_ctrl_lane #(
   parameter int AXES            = gip_pkg::AXES_DEFAULT,
   parameter int VIRTUAL_BUTTONS = gip_pkg::VIRTUAL_BUTTONS_DEFAULT
) (
   input  gip_pkg::source_type          src,
   input  logic                         invert,
   input  logic [31:0]                  buttons,
   input  logic [15:0]                  hats,
   input  gip_pkg::axis_type            axis_val [AXES],
   input  logic [AXES-1:0]              axis_en,
   output gip_pkg::control_type         value,
   output logic [VIRTUAL_BUTTONS-1:0]   claimed
);

   localparam int AIDX_W = (AXES > 1) ? $clog2(AXES) : 1;

   logic                 off;
   logic                 is_pair;
   logic                 is_hat;
   logic                 neg_hit;
   logic                 pos_hit;
   logic [7:0]           lo_byte;
   logic [7:0]           hi_byte;
   logic [3:0]           hv;
   logic [AIDX_W-1:0]    ax_idx;
   logic                 ax_ok;
   gip_pkg::axis_type    ax;
   gip_pkg::control_type r;

   assign off     = src[gip_pkg::SRC_OFF_BIT];
   assign is_pair = src[gip_pkg::SRC_PAIR_BIT];
   assign is_hat  = src[gip_pkg::SRC_HAT_BIT];
   assign lo_byte = src[7:0];
   assign hi_byte = src[15:8];

   always_comb begin
      neg_hit = (lo_byte[7:5] == 3'd0) && buttons[lo_byte[4:0]];
      pos_hit = (hi_byte[7:5] == 3'd0) && buttons[hi_byte[4:0]];
      hv      = (lo_byte < 8'd4) ? hats[lo_byte[1:0] * 4 +: 4] : 4'd0;
      ax_idx  = src[AIDX_W-1:0];
      ax_ok   = (src[15:0] < 16'(AXES)) && axis_en[ax_idx];
      ax      = axis_val[ax_idx];
      r       = '0;
      if (off) begin
         r = '0;
      end else if (is_pair) begin
         if (neg_hit) begin
            r = r - gip_pkg::FULL_SCALE;
         end
         if (pos_hit) begin
            r = r + gip_pkg::FULL_SCALE;
         end
      end else if (is_hat) begin
         // Left beats right and up beats down when both are set.
         if (hi_byte == gip_pkg::DIR_HORIZONTAL) begin
            if (hv[gip_pkg::HAT_LEFT]) begin
               r = -gip_pkg::FULL_SCALE;
            end else if (hv[gip_pkg::HAT_RIGHT]) begin
               r = gip_pkg::FULL_SCALE;
            end
         end else if (hi_byte == gip_pkg::DIR_VERTICAL) begin
            if (hv[gip_pkg::HAT_UP]) begin
               r = -gip_pkg::FULL_SCALE;
            end else if (hv[gip_pkg::HAT_DOWN]) begin
               r = gip_pkg::FULL_SCALE;
            end
         end
      end else if (ax_ok) begin
         if (ax < gip_pkg::DEAD_ZONE && ax > -gip_pkg::DEAD_ZONE) begin
            r = '0;
         end else begin
            r = {ax[15], ax};
         end
      end
      value = invert ? -r : r;
   end

   for (genvar i = 0; i < VIRTUAL_BUTTONS; i++) begin : g_claim
      assign claimed[i] = !off && is_pair && (lo_byte == 8'(i) || hi_byte == 8'(i));
   end

endmodule

>>> src/gip_emit.sv
module gip_emit #(
   parameter int AXES            = gip_pkg::AXES_DEFAULT,
   parameter int VIRTUAL_BUTTONS = gip_pkg::VIRTUAL_BUTTONS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [VIRTUAL_BUTTONS-1:0]   buttons,
   input  logic [AXES-1:0]              above,
   input  logic [AXES-1:0]              below,
   input  logic [3:0]                   hat0,
   input  gip_pkg::control_type         turn,
   input  gip_pkg::control_type         forward,
   input  gip_pkg::control_type         strafe,
   input  gip_pkg::control_type         look,
   gip_rsp_if.source                    rsp_ch,
   output gip_pkg::emit_status_type     status
);

   localparam int MB = VIRTUAL_BUTTONS + 16;

   logic [MB-1:0] mask;

   for (genvar i = 0; i < VIRTUAL_BUTTONS; i++) begin : g_btn
      assign mask[i] = buttons[i];
   end

   // Above the buttons: positive axis signs, negative axis signs, then hat 0.
   for (genvar p = VIRTUAL_BUTTONS; p < MB; p++) begin : g_ext
      localparam int O = p - VIRTUAL_BUTTONS;
      if (O < AXES) begin : g_pos
         assign mask[p] = above[O];
      end else if (O < 2 * AXES) begin : g_neg
         assign mask[p] = below[O - AXES];
      end else if (O < 2 * AXES + 4) begin : g_hat
         assign mask[p] = hat0[O - 2 * AXES];
      end else begin : g_zero
         assign mask[p] = 1'b0;
      end
   end

   function automatic gip_pkg::index_type low_index(input logic [MB-1:0] v);
      gip_pkg::index_type r;
      r = '0;
      for (int p = MB - 1; p >= 0; p--) begin
         if (v[p]) begin
            r = gip_pkg::index_type'(p);
         end
      end
      return r;
   endfunction

   logic [MB-1:0]        prev_ff, prev_in;
   logic [MB-1:0]        press_ff, press_in;
   logic [MB-1:0]        release_ff, release_in;
   logic                 motion_ff, motion_in;
   gip_pkg::control_type turn_ff, forward_ff, strafe_ff, look_ff;
   logic                 valid_ff, valid_in;
   gip_pkg::kind_type    kind_ff, kind_in;
   gip_pkg::index_type   idx_ff, idx_in;
   gip_pkg::control_type o_turn_ff, o_turn_in, o_fwd_ff, o_fwd_in;
   gip_pkg::control_type o_str_ff, o_str_in, o_look_ff, o_look_in;
   logic                 last_ff, last_in;
   logic [MB-1:0]        press_rest, release_rest;
   logic                 pending, take;

   always_comb begin
      press_rest   = press_ff & (press_ff - 1'b1);
      release_rest = release_ff & (release_ff - 1'b1);
      pending      = motion_ff || (|press_ff) || (|release_ff);
      take         = pending && (!valid_ff || rsp_ch.ready);

      prev_in    = prev_ff;
      press_in   = press_ff;
      release_in = release_ff;
      motion_in  = motion_ff;
      valid_in   = valid_ff;
      kind_in    = kind_ff;
      idx_in     = idx_ff;
      o_turn_in  = o_turn_ff;
      o_fwd_in   = o_fwd_ff;
      o_str_in   = o_str_ff;
      o_look_in  = o_look_ff;
      last_in    = last_ff;

      if (take) begin
         valid_in  = 1'b1;
         o_turn_in = '0;
         o_fwd_in  = '0;
         o_str_in  = '0;
         o_look_in = '0;
         idx_in    = '0;
         priority if (motion_ff) begin
            kind_in   = gip_pkg::KIND_MOTION;
            o_turn_in = turn_ff;
            o_fwd_in  = forward_ff;
            o_str_in  = strafe_ff;
            o_look_in = look_ff;
            last_in   = (press_ff == '0) && (release_ff == '0);
            motion_in = 1'b0;
         end else if (|press_ff) begin
            kind_in  = gip_pkg::KIND_PRESS;
            idx_in   = low_index(press_ff);
            last_in  = (press_rest == '0) && (release_ff == '0);
            press_in = press_rest;
         end else begin
            kind_in    = gip_pkg::KIND_RELEASE;
            idx_in     = low_index(release_ff);
            last_in    = (release_rest == '0);
            release_in = release_rest;
         end
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end

      // A new poll is loaded only once the previous one has fully drained.
      if (load) begin
         press_in   = mask & ~prev_ff;
         release_in = prev_ff & ~mask;
         prev_in    = mask;
         motion_in  = (turn != '0) || (forward != '0) || (strafe != '0) || (look != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         press_ff   <= '0;
         release_ff <= '0;
         motion_ff  <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         prev_ff    <= prev_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         motion_ff  <= motion_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         turn_ff    <= turn;
         forward_ff <= forward;
         strafe_ff  <= strafe;
         look_ff    <= look;
      end
      kind_ff   <= kind_in;
      idx_ff    <= idx_in;
      o_turn_ff <= o_turn_in;
      o_fwd_ff  <= o_fwd_in;
      o_str_ff  <= o_str_in;
      o_look_ff <= o_look_in;
      last_ff   <= last_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.kind          = kind_ff;
   assign rsp_ch.button_index  = idx_ff;
   assign rsp_ch.turn_value    = o_turn_ff;
   assign rsp_ch.forward_value = o_fwd_ff;
   assign rsp_ch.strafe_value  = o_str_ff;
   assign rsp_ch.look_value    = o_look_ff;
   assign rsp_ch.last          = last_ff;

   assign status.pending = pending;
   assign status.valid   = valid_ff;

endmodule

>>> tb/sv/tb_gamepad_input_qualifier.sv
module tb_gamepad_input_qualifier;
   timeunit 1ns;
   timeprecision 1ps;

   import gip_pkg::*;

   localparam int VB              = VIRTUAL_BUTTONS_DEFAULT;
   localparam int NAX             = AXES_DEFAULT;
   localparam int MASK_W          = VB + 16;
   localparam int SETTLE_CYCLES   = 40;
   localparam int LONG_HOLD       = 300;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 52;
   localparam source_type SOURCE_DISABLED = '1;

   typedef struct {
      logic        cmd;
      logic [31:0] buttons;
      logic [15:0] hats;
      axis_type    axes[NAX];
   } poll_item_t;

   typedef struct {
      kind_type    kind;
      index_type   index;
      control_type look;
      control_type turn;
      control_type forward;
      control_type strafe;
      logic        last;
   } qual_result_t;

   typedef struct {
      logic [2:0] axis_count;
      logic [5:0] button_count;
      logic [2:0] hat_count;
      source_type src[4];  // turn, forward, strafe, look
      logic [3:0] invert;
   } cfg_t;

   // A directed row; n_typed < 0 means the predictor supplies the expectation.
   typedef struct {
      int           cfg_sel;
      int           n_typed;
      poll_item_t   item;
      qual_result_t typed[3];
   } row_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   csr_index_type    csr_index;
   logic [18:0]      csr_wdata;

   gip_req_if req_ch ();
   gip_rsp_if rsp_ch ();

   gamepad_input_qualifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state, mirrored from what has been written and accepted.
   cfg_t         active_cfg;
   axis_type     offset_now[NAX];
   logic [MASK_W-1:0] held_buttons;
   qual_result_t expected_results[$];

   int  mismatches     = 0;
   int  items_sent     = 0;
   int  calibrations   = 0;
   int  cfg_writes     = 0;
   int  motion_seen    = 0;
   int  press_seen     = 0;
   int  release_seen   = 0;
   bit  steady         = 1'b0;
   bit  hold_request   = 1'b0;

   function automatic int used_axes();
      return (active_cfg.axis_count < NAX) ? int'(active_cfg.axis_count) : NAX;
   endfunction

   function automatic int used_buttons();
      return (active_cfg.button_count < PHYS_BUTTONS_DEFAULT) ?
             int'(active_cfg.button_count) : PHYS_BUTTONS_DEFAULT;
   endfunction

   function automatic int used_hats();
      return (active_cfg.hat_count < HATS_DEFAULT) ? int'(active_cfg.hat_count) : HATS_DEFAULT;
   endfunction

   function automatic int corrected(input poll_item_t it, input int i);
      int v;
      v = int'(it.axes[i]) - int'(offset_now[i]);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic logic button_on(input poll_item_t it, input int b);
      if (b >= used_buttons()) return 1'b0;
      return it.buttons[b];
   endfunction

   // A button claimed by an enabled button-pair source never shows in the mask.
   function automatic logic pair_claims(input int b);
      source_type s;
      for (int k = 0; k < 4; k++) begin
         s = active_cfg.src[k];
         if (!s[SRC_OFF_BIT] && s[SRC_PAIR_BIT] && (b == int'(s[7:0]) || b == int'(s[15:8])))
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int control_level(input poll_item_t it, input int k);
      int          r;
      int          hat;
      int          dir;
      logic [17:0] u;
      logic [3:0]  hv;
      r = 0;
      if (active_cfg.src[k][SRC_OFF_BIT]) return 0;
      u = active_cfg.src[k][17:0];
      if (u[SRC_PAIR_BIT]) begin
         if (button_on(it, int'(u[7:0]))) r -= int'(FULL_SCALE);
         if (button_on(it, int'(u[15:8]))) r += int'(FULL_SCALE);
      end else if (u[SRC_HAT_BIT]) begin
         hat = int'(u[7:0]);
         dir = int'(u[15:8]);
         if (hat < used_hats()) begin
            hv = 4'(it.hats >> (4 * hat));
            // Left beats right and up beats down when both are reported.
            if (dir == int'(DIR_HORIZONTAL)) begin
               if (hv[HAT_LEFT]) r = -int'(FULL_SCALE);
               else if (hv[HAT_RIGHT]) r = int'(FULL_SCALE);
            end else if (dir == int'(DIR_VERTICAL)) begin
               if (hv[HAT_UP]) r = -int'(FULL_SCALE);
               else if (hv[HAT_DOWN]) r = int'(FULL_SCALE);
            end
         end
      end else if (int'(u) < used_axes()) begin
         r = corrected(it, int'(u));
         if (r < DEAD_ZONE && r > -DEAD_ZONE) r = 0;
      end
      if (active_cfg.invert[k]) r = -r;
      return r;
   endfunction

   function automatic logic [MASK_W-1:0] virtual_mask(input poll_item_t it);
      logic [MASK_W-1:0] m;
      int                a;
      m = '0;
      for (int i = 0; i < VB; i++)
         if (!pair_claims(i) && button_on(it, i)) m[i] = 1'b1;
      for (int i = 0; i < used_axes(); i++) begin
         a = corrected(it, i);
         if (a > DEAD_ZONE) m[VB + i] = 1'b1;
         else if (a < -DEAD_ZONE) m[VB + NAX + i] = 1'b1;
      end
      if (used_hats() > 0)
         for (int j = 0; j < 4; j++)
            if (it.hats[j]) m[VB + 2 * NAX + j] = 1'b1;
      return m;
   endfunction

   function automatic qual_result_t make_result(input kind_type kind, input int idx,
                                                input int look, input int turn,
                                                input int fwd, input int strafe,
                                                input logic last);
      qual_result_t q;
      q.kind    = kind;
      q.index   = index_type'(idx);
      q.look    = control_type'(look);
      q.turn    = control_type'(turn);
      q.forward = control_type'(fwd);
      q.strafe  = control_type'(strafe);
      q.last    = last;
      return q;
   endfunction

   function automatic void qualify_poll(input poll_item_t it, ref qual_result_t out_q[$]);
      int                v[4];
      logic [MASK_W-1:0] now_mask;
      logic [MASK_W-1:0] bits;
      out_q = {};
      if (it.cmd == CMD_CALIBRATE) begin
         for (int i = 0; i < used_axes(); i++) offset_now[i] = it.axes[i];
         return;
      end
      for (int k = 0; k < 4; k++) v[k] = control_level(it, k);
      if (v[0] != 0 || v[1] != 0 || v[2] != 0 || v[3] != 0)
         out_q.push_back(make_result(KIND_MOTION, 0, v[3], v[0], v[1], v[2], 1'b0));
      now_mask = virtual_mask(it);
      bits = now_mask & ~held_buttons;
      for (int i = 0; i < MASK_W; i++)
         if (bits[i]) out_q.push_back(make_result(KIND_PRESS, i, 0, 0, 0, 0, 1'b0));
      bits = held_buttons & ~now_mask;
      held_buttons = now_mask;
      for (int i = 0; i < MASK_W; i++)
         if (bits[i]) out_q.push_back(make_result(KIND_RELEASE, i, 0, 0, 0, 0, 1'b0));
      if (out_q.size() > 0) out_q[out_q.size() - 1].last = 1'b1;
   endfunction

   function automatic source_type pair_src(input logic [7:0] neg, input logic [7:0] pos);
      return source_type'((1 << SRC_PAIR_BIT) | (int'(pos) << 8) | int'(neg));
   endfunction

   function automatic source_type hat_src(input logic [7:0] hat, input logic [7:0] dir);
      return source_type'((1 << SRC_HAT_BIT) | (int'(dir) << 8) | int'(hat));
   endfunction

   function automatic cfg_t make_cfg(input int axes, input int buttons, input int hats,
                                     input source_type turn, input source_type fwd,
                                     input source_type strafe, input source_type look,
                                     input int inv);
      cfg_t c;
      c.axis_count   = 3'(axes);
      c.button_count = 6'(buttons);
      c.hat_count    = 3'(hats);
      c.src[0]       = turn;
      c.src[1]       = fwd;
      c.src[2]       = strafe;
      c.src[3]       = look;
      c.invert       = 4'(inv);
      return c;
   endfunction

   function automatic source_type random_source();
      logic [7:0] lo;
      logic [7:0] hi;
      lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 33));
      hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 33));
      case ($urandom_range(0, 9))
         0:       return source_type'((1 << SRC_OFF_BIT) | int'($urandom_range(0, 262143)));
         1, 2:    return source_type'($urandom_range(0, 7));
         3:       return source_type'($urandom_range(0, 65535));
         4, 5:    return pair_src(lo, hi);
         6:       return pair_src(lo, hi) | source_type'(1 << SRC_HAT_BIT);
         default: return hat_src(8'($urandom_range(0, 5)),
                                 ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                                                               8'($urandom_range(0, 3)));
      endcase
   endfunction

   function automatic cfg_t random_config();
      cfg_t c;
      c = make_cfg($urandom_range(0, 1) ? NAX : int'($urandom_range(0, NAX)),
                   $urandom_range(0, 1) ? PHYS_BUTTONS_DEFAULT : int'($urandom_range(0, 32)),
                   $urandom_range(0, 1) ? HATS_DEFAULT : int'($urandom_range(0, 4)),
                   random_source(), random_source(), random_source(), random_source(),
                   int'($urandom_range(0, 15)));
      return c;
   endfunction

   function automatic axis_type random_axis();
      case ($urandom_range(0, 7))
         0:       return axis_type'(32767);
         1:       return axis_type'(-32768);
         2:       return axis_type'(DEAD_ZONE + int'($urandom_range(0, 2)) - 1);
         3:       return axis_type'(-DEAD_ZONE + int'($urandom_range(0, 2)) - 1);
         4:       return axis_type'(int'($urandom_range(0, 400)) - 200);
         default: return axis_type'($urandom);
      endcase
   endfunction

   // Most polls differ a little from the previous one, as a real pad does.
   function automatic poll_item_t random_item(input poll_item_t prev);
      poll_item_t it;
      int         sel;
      it = prev;
      it.cmd = CMD_POLL;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         it.cmd = CMD_CALIBRATE;
         foreach (it.axes[i])
            if ($urandom_range(0, 1)) it.axes[i] = random_axis();
      end else if (sel < 62) begin
         it.buttons ^= 32'h1 << $urandom_range(0, 31);
         if ($urandom_range(0, 1)) it.buttons ^= 32'h1 << $urandom_range(0, 14);
         if ($urandom_range(0, 1)) it.axes[$urandom_range(0, NAX - 1)] = random_axis();
         if ($urandom_range(0, 2) == 0) it.hats ^= 16'h1 << $urandom_range(0, 15);
      end else if (sel < 72) begin
         it.hats = 16'($urandom);
      end else if (sel >= 80) begin
         it.buttons = $urandom;
         it.hats    = 16'($urandom);
         foreach (it.axes[i]) it.axes[i] = random_axis();
      end
      return it;
   endfunction

   function automatic row_t mk_row(input int sel, input int n_typed, input logic cmd,
                                   input logic [31:0] b, input logic [15:0] h,
                                   input int a0, input int a1, input int a2,
                                   input int a3, input int a4, input int a5);
      row_t r;
      r.cfg_sel      = sel;
      r.n_typed      = n_typed;
      r.item.cmd     = cmd;
      r.item.buttons = b;
      r.item.hats    = h;
      r.item.axes[0] = axis_type'(a0);
      r.item.axes[1] = axis_type'(a1);
      r.item.axes[2] = axis_type'(a2);
      r.item.axes[3] = axis_type'(a3);
      r.item.axes[4] = axis_type'(a4);
      r.item.axes[5] = axis_type'(a5);
      return r;
   endfunction

   task automatic apply_config(input cfg_t c);
      csr_index_type regs[8];
      logic [18:0]   data[8];
      regs = '{CSR_AXIS_COUNT, CSR_BUTTON_COUNT, CSR_HAT_COUNT, CSR_TURN_SOURCE,
               CSR_FORWARD_SOURCE, CSR_STRAFE_SOURCE, CSR_LOOK_SOURCE, CSR_INVERT_MASK};
      data = '{19'(c.axis_count), 19'(c.button_count), 19'(c.hat_count), c.src[0],
               c.src[1], c.src[2], c.src[3], 19'(c.invert)};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= data[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      active_cfg = c;
      cfg_writes++;
   endtask

   // Lets the block drain; polls without results may still be in flight.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_row(input row_t r);
      int           gap;
      qual_result_t predicted[$];
      gap = steady ? 0 : int'($urandom_range(0, 4));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= r.item.cmd;
      req_ch.raw_buttons <= r.item.buttons;
      req_ch.raw_hats    <= r.item.hats;
      req_ch.raw_axis_a  <= r.item.axes[0];
      req_ch.raw_axis_b  <= r.item.axes[1];
      req_ch.raw_axis_c  <= r.item.axes[2];
      req_ch.raw_axis_d  <= r.item.axes[3];
      req_ch.raw_axis_e  <= r.item.axes[4];
      req_ch.raw_axis_f  <= r.item.axes[5];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // The predictor still runs on typed rows so that its state stays in step.
      qualify_poll(r.item, predicted);
      if (r.n_typed >= 0) begin
         for (int i = 0; i < r.n_typed; i++) expected_results.push_back(r.typed[i]);
      end else begin
         foreach (predicted[i]) expected_results.push_back(predicted[i]);
      end
      items_sent++;
      if (r.item.cmd == CMD_CALIBRATE) calibrations++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin : receiver
      int gap;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = steady ? 0 : int'($urandom_range(0, 4));
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   qual_result_t want;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d index %0d", rsp_ch.kind, rsp_ch.button_index);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, rsp_ch.kind);
            check_field("button_index", want.index, rsp_ch.button_index);
            check_field("look_value", want.look, rsp_ch.look_value);
            check_field("turn_value", want.turn, rsp_ch.turn_value);
            check_field("forward_value", want.forward, rsp_ch.forward_value);
            check_field("strafe_value", want.strafe, rsp_ch.strafe_value);
            check_field("last", want.last, rsp_ch.last);
         end
         case (rsp_ch.kind)
            KIND_MOTION:  motion_seen++;
            KIND_PRESS:   press_seen++;
            KIND_RELEASE: release_seen++;
            default: ;
         endcase
      end
   end

   initial begin : stimulus
      row_t       dir_rows[$];
      row_t       r;
      cfg_t       settings[6];
      poll_item_t prev;

      csr_we             <= 1'b0;
      csr_index          <= CSR_AXIS_COUNT;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_POLL;
      req_ch.raw_buttons <= '0;
      req_ch.raw_hats    <= '0;
      req_ch.raw_axis_a  <= '0;
      req_ch.raw_axis_b  <= '0;
      req_ch.raw_axis_c  <= '0;
      req_ch.raw_axis_d  <= '0;
      req_ch.raw_axis_e  <= '0;
      req_ch.raw_axis_f  <= '0;

      active_cfg   = make_cfg(0, 0, 0, SOURCE_DISABLED, SOURCE_DISABLED, SOURCE_DISABLED,
                              SOURCE_DISABLED, 0);
      held_buttons = '0;
      foreach (offset_now[i]) offset_now[i] = '0;

      settings[0] = active_cfg;
      settings[1] = make_cfg(NAX, PHYS_BUTTONS_DEFAULT, HATS_DEFAULT, source_type'(0),
                             source_type'(1), pair_src(2, 3), hat_src(0, DIR_HORIZONTAL), 0);
      // Both type flags on forward, an unknown hat direction on look.
      settings[2] = make_cfg(NAX, PHYS_BUTTONS_DEFAULT, HATS_DEFAULT,
                             hat_src(1, DIR_VERTICAL),
                             pair_src(16, 31) | source_type'(1 << SRC_HAT_BIT),
                             source_type'(5), hat_src(3, DIR_HORIZONTAL | DIR_VERTICAL), 15);
      // Sources that name an axis, a button and a hat the device does not have.
      settings[3] = make_cfg(3, 20, 1, source_type'(4), pair_src(40, 5),
                             hat_src(2, DIR_HORIZONTAL), source_type'(2), 5);
      settings[4] = make_cfg(0, 0, 0, source_type'(0), pair_src(0, 1),
                             hat_src(0, DIR_VERTICAL), source_type'(300), 15);
      settings[5] = make_cfg(NAX, PHYS_BUTTONS_DEFAULT, HATS_DEFAULT,
                             source_type'(1 << SRC_OFF_BIT), SOURCE_DISABLED,
                             source_type'((1 << SRC_OFF_BIT) | pair_src(2, 1)),
                             source_type'((1 << SRC_OFF_BIT) | (1 << SRC_HAT_BIT)), 10);

      // Reset values: nothing is present, so nothing comes out.
      dir_rows.push_back(mk_row(0, 0, CMD_POLL, '1, '1,
                                32767, -32768, 32767, -32768, 32767, -32768));
      dir_rows.push_back(mk_row(-1, 0, CMD_CALIBRATE, '1, '1,
                                32767, -32768, 32767, -32768, 32767, -32768));
      dir_rows.push_back(mk_row(1, 0, CMD_POLL, '0, '0, 0, 0, 0, 0, 0, 0));
      r = mk_row(-1, 1, CMD_POLL, 32'h1, '0, 0, 0, 0, 0, 0, 0);
      r.typed[0] = make_result(KIND_PRESS, 0, 0, 0, 0, 0, 1'b1);
      dir_rows.push_back(r);
      r = mk_row(-1, 3, CMD_POLL, '0, '0, 32767, 0, 0, 0, 0, 0);
      r.typed[0] = make_result(KIND_MOTION, 0, 0, 32767, 0, 0, 1'b0);
      r.typed[1] = make_result(KIND_PRESS, VB, 0, 0, 0, 0, 1'b0);
      r.typed[2] = make_result(KIND_RELEASE, 0, 0, 0, 0, 0, 1'b1);
      dir_rows.push_back(r);
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, '1, '1,
                                -32768, -32768, -32768, -32768, -32768, -32768));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, '0, '0,
                                DEAD_ZONE, -DEAD_ZONE, DEAD_ZONE + 1, -DEAD_ZONE - 1,
                                DEAD_ZONE - 1, -DEAD_ZONE + 1));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, 32'h8, 16'h0002, 0, 0, 0, 0, 0, 0));
      // Offsets at both rails push the corrected value past 16 bits.
      dir_rows.push_back(mk_row(-1, -1, CMD_CALIBRATE, '0, '0,
                                -32768, -32768, -32768, -32768, -32768, -32768));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, '0, '0,
                                32767, 32767, 32767, 32767, 32767, 32767));
      dir_rows.push_back(mk_row(-1, -1, CMD_CALIBRATE, '0, '0,
                                32767, 32767, 32767, 32767, 32767, 32767));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, '0, '0,
                                -32768, -32768, -32768, -32768, -32768, -32768));
      dir_rows.push_back(mk_row(-1, -1, CMD_CALIBRATE, '0, '0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(2, -1, CMD_POLL, '0, '0, 0, 0, 0, 0, 0, -32768));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, 32'h8000_0000, 16'h0050,
                                0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, 32'h0001_7fff, 16'hf0a0,
                                0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, '0, '0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(3, -1, CMD_POLL, '1, '1,
                                20000, -20000, 32767, -32768, 32767, 5));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, 32'h000f_ffff, 16'h000f,
                                0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, '0, '0, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(4, -1, CMD_POLL, '1, '1,
                                32767, 32767, 32767, 32767, 32767, 32767));
      dir_rows.push_back(mk_row(-1, -1, CMD_CALIBRATE, '0, '0,
                                1234, -1234, 4321, -4321, 99, -99));
      dir_rows.push_back(mk_row(5, -1, CMD_POLL, '1, '1,
                                12000, -12000, 12000, -12000, 12000, -12000));
      dir_rows.push_back(mk_row(-1, -1, CMD_POLL, '0, '0, 0, 0, 0, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].cfg_sel >= 0) begin
            settle();
            apply_config(settings[dir_rows[i].cfg_sel]);
         end
         send_row(dir_rows[i]);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         apply_config((p == 0) ? settings[1] : random_config());
         steady = (p == RANDOM_PHASES - 2);
         // The long hold-off lets the sender keep pushing into a full block.
         if (p == 2) hold_request = 1'b1;
         prev.cmd     = CMD_POLL;
         prev.buttons = '0;
         prev.hats    = '0;
         foreach (prev.axes[i]) prev.axes[i] = '0;
         repeat (ITEMS_PER_PHASE) begin
            prev      = random_item(prev);
            r.cfg_sel = -1;
            r.n_typed = -1;
            r.item    = prev;
            send_row(r);
         end
      end
      steady = 1'b0;
      settle();

      $display("Sent %0d items (%0d calibrations) under %0d register settings.",
               items_sent, calibrations, cfg_writes);
      $display("Checked %0d motion, %0d press and %0d release results.",
               motion_seen, press_seen, release_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> gamepad_input_qualifier.f
src/gip_pkg.sv
src/gip_req_if.sv
src/gip_rsp_if.sv
src/gip_axis_lane.sv
src/gip_ctrl_lane.sv
src/gip_emit.sv
src/gamepad_input_qualifier.sv
tb/sv/tb_gamepad_input_qualifier.sv
